### rtl/bmpx_pkg.sv
// Package with types, constants and mask decoding for the BMP pixel to XRGB converter.
`timescale 1ns / 1ps

package bmpx_pkg;

	localparam int NUM_CH    = 3;
	localparam int CH_RED    = 0;
	localparam int CH_GREEN  = 1;
	localparam int CH_BLUE   = 2;
	localparam int QUO_W     = 8;
	localparam int DIV_STEPS = QUO_W;
	localparam int PIPE_LAT  = DIV_STEPS + 3;

	typedef enum logic [1:0] {
		CFG_FORMAT     = 2'd0,
		CFG_RED_MASK   = 2'd1,
		CFG_GREEN_MASK = 2'd2,
		CFG_BLUE_MASK  = 2'd3
	} cfg_idx_t;

	localparam logic [1:0] FMT_BITFIELDS = 2'd2;

	typedef struct packed {
		logic [31:0] mask;
		logic [4:0]  low;
		logic [31:0] div;
		logic        zero;
	} chan_cfg_t;

	localparam chan_cfg_t CHAN_CFG_RST = '{mask: 32'd0, low: 5'd0, div: 32'd0, zero: 1'b1};

	// The divisor is the mask smeared down from its top bit, shifted by its lowest set bit.
	function automatic chan_cfg_t chan_cfg(input logic [31:0] mask);
		logic [31:0] lsb;
		logic [31:0] smear;
		logic [4:0]  low;
		chan_cfg_t   c;
		lsb = mask & (~mask + 32'd1);
		low = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (lsb[i]) begin
				low = low | 5'(i);
			end
		end
		smear = mask;
		for (int k = 0; k < 5; k++) begin
			smear = smear | (smear >> (1 << k));
		end
		c.mask = mask;
		c.low  = low;
		c.div  = smear >> low;
		c.zero = (mask == 32'd0);
		return c;
	endfunction

endpackage

### rtl/bmp_pixel_to_xrgb_converter.sv
// Top level of the BMP pixel to XRGB converter: mask extraction, scaling and pipelined divide.
//
// Channel  Handshake              Payload
// input    start, busy            pixel_word
// result   done                   xrgb_pixel
// config   cfg_valid, cfg_ready   cfg_index, cfg_data
//
// One pixel is taken every clock cycle; busy stays low and cfg_ready stays high.
// The pipeline has eleven register stages, eight of them one-bit divide steps: a result
// passes s1, s2, the divide steps and s11 in that order before it is on the ports.
// Reset clears the configuration registers and all valid bits of the pipeline.
// The pipeline never stalls, since done marks a result that is taken in that same cycle.
`timescale 1ns / 1ps

module bmp_pixel_to_xrgb_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] pixel_word,
	output logic        done,
	output logic [23:0] xrgb_pixel,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import bmpx_pkg::*;

	logic [1:0] format_q;
	chan_cfg_t  ch_q [NUM_CH];
	logic       cfg_we;
	logic       in_acc;

	logic                 vld_s1;
	logic                 vld_s2;
	logic [DIV_STEPS-1:0] vld_sn;
	logic                 vld_s11;

	logic [23:0] pix_s1;
	logic [23:0] pix_s2;
	logic [23:0] pix_sn [DIV_STEPS];
	logic [23:0] xrgb_s11;
	logic [23:0] xrgb_nx;

	logic [31:0] fld_nx [NUM_CH];
	logic [31:0] fld_s1 [NUM_CH];
	logic [31:0] rem_s2 [NUM_CH];

	logic [31:0]      rem_in [DIV_STEPS][NUM_CH];
	logic [QUO_W-1:0] quo_in [DIV_STEPS][NUM_CH];
	logic [39:0]      dsh    [DIV_STEPS][NUM_CH];
	logic             take   [DIV_STEPS][NUM_CH];
	logic [31:0]      rem_nx [DIV_STEPS][NUM_CH];
	logic [QUO_W-1:0] quo_nx [DIV_STEPS][NUM_CH];
	logic [31:0]      rem_sn [DIV_STEPS][NUM_CH];
	logic [QUO_W-1:0] quo_sn [DIV_STEPS][NUM_CH];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign in_acc    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= 2'd0;
			for (int c = 0; c < NUM_CH; c++) begin
				ch_q[c] <= CHAN_CFG_RST;
			end
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FORMAT:     format_q         <= cfg_data[1:0];
				CFG_RED_MASK:   ch_q[CH_RED]     <= chan_cfg(cfg_data);
				CFG_GREEN_MASK: ch_q[CH_GREEN]   <= chan_cfg(cfg_data);
				CFG_BLUE_MASK:  ch_q[CH_BLUE]    <= chan_cfg(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_sn  <= '0;
			vld_s11 <= 1'b0;
		end else begin
			vld_s1  <= in_acc;
			vld_s2  <= vld_s1;
			vld_sn  <= {vld_sn[DIV_STEPS-2:0], vld_s2};
			vld_s11 <= vld_sn[DIV_STEPS-1];
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			fld_nx[c] = (pixel_word & ch_q[c].mask) >> ch_q[c].low;
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			rem_in[0][c] = rem_s2[c];
			quo_in[0][c] = '0;
		end
		for (int j = 1; j < DIV_STEPS; j++) begin
			for (int c = 0; c < NUM_CH; c++) begin
				rem_in[j][c] = rem_sn[j-1][c];
				quo_in[j][c] = quo_sn[j-1][c];
			end
		end
		for (int j = 0; j < DIV_STEPS; j++) begin
			for (int c = 0; c < NUM_CH; c++) begin
				dsh[j][c]    = {8'd0, ch_q[c].div} << (DIV_STEPS - 1 - j);
				take[j][c]   = ({8'd0, rem_in[j][c]} >= dsh[j][c]);
				rem_nx[j][c] = take[j][c] ? 32'({8'd0, rem_in[j][c]} - dsh[j][c])
				                          : rem_in[j][c];
				quo_nx[j][c] = {quo_in[j][c][QUO_W-2:0], take[j][c]};
			end
		end
	end

	always_comb begin
		if (format_q == FMT_BITFIELDS) begin
			for (int c = 0; c < NUM_CH; c++) begin
				xrgb_nx[8*(NUM_CH-1-c) +: 8] = ch_q[c].zero ? 8'd0 : quo_sn[DIV_STEPS-1][c];
			end
		end else begin
			xrgb_nx = pix_sn[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= pixel_word[23:0];
		fld_s1 <= fld_nx;
		pix_s2 <= pix_s1;
		for (int c = 0; c < NUM_CH; c++) begin
			rem_s2[c] <= (fld_s1[c] << 8) - fld_s1[c];
		end
		pix_sn[0] <= pix_s2;
		for (int j = 1; j < DIV_STEPS; j++) begin
			pix_sn[j] <= pix_sn[j-1];
		end
		rem_sn   <= rem_nx;
		quo_sn   <= quo_nx;
		xrgb_s11 <= xrgb_nx;
	end

	assign done       = vld_s11;
	assign xrgb_pixel = xrgb_s11;

`ifndef SYNTHESIS
	for (genvar j = 0; j < DIV_STEPS - 1; j++) begin : g_chk_quo
		for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
			a_quo_width: assert property (@(posedge clk) disable iff (!arst_n)
				vld_sn[j] |-> ((quo_sn[j][c] >> (j + 1)) == '0))
				else $error("Quotient holds more bits than divide steps done.");
		end
	end

	for (genvar j = 1; j < DIV_STEPS; j++) begin : g_chk_rem
		for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
			a_rem_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
				vld_sn[j] |-> (rem_sn[j][c] <= $past(rem_sn[j-1][c])))
				else $error("Remainder grew across a divide step.");
		end
	end

	for (genvar c = 0; c < NUM_CH; c++) begin : g_chk_zero
		a_zero_mask: assert property (@(posedge clk) disable iff (!arst_n)
			done && $past((format_q == FMT_BITFIELDS) && ch_q[c].zero)
			|-> (xrgb_pixel[8*(NUM_CH-1-c) +: 8] == 8'd0))
			else $error("Channel with an empty mask is not zero.");
	end
`endif

endmodule

### verif/tb_top.sv
// Self-checking testbench for the BMP pixel to XRGB converter with its own pixel decoder.
`timescale 1ns / 1ps

module tb_top;

	import bmpx_pkg::*;

	localparam logic [1:0] FMT_BGR24  = 2'd0;
	localparam logic [1:0] FMT_BGRX32 = 2'd1;
	localparam logic [1:0] FMT_SPARE  = 2'd3;
	localparam int RANDOM_PHASES = 14;
	localparam int PIXELS_PER_PHASE = 50;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] pixel_word = 32'd0;
	logic        done;
	logic [23:0] xrgb_pixel;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [31:0] cfg_data = 32'd0;

	logic [1:0]  fmt_now = FMT_BGR24;
	logic [31:0] red_mask_now = 32'd0;
	logic [31:0] green_mask_now = 32'd0;
	logic [31:0] blue_mask_now = 32'd0;

	logic [23:0] expected_pixels[$];
	int pixels_sent = 0;
	int pixels_checked = 0;
	int mismatches = 0;
	int unexpected = 0;
	int settings_used = 0;
	logic [3:0] formats_seen = 4'd0;

	bmp_pixel_to_xrgb_converter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel_word(pixel_word),
		.done(done),
		.xrgb_pixel(xrgb_pixel),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("Timed out with %0d pixels still outstanding.", expected_pixels.size());
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [7:0] scale_channel(input logic [31:0] word, input logic [31:0] mask);
		int lsb;
		int width;
		logic [31:0] full;
		logic [31:0] field;
		logic [31:0] product;
		logic [31:0] quotient;
		if (mask == 32'd0) begin
			return 8'd0;
		end
		lsb = 0;
		while (lsb < 31 && !mask[lsb]) begin
			lsb++;
		end
		width = 0;
		for (int i = lsb; i < 32; i++) begin
			if (mask[i]) begin
				width = i - lsb + 1;
			end
		end
		full = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
		field = (word & mask) >> lsb;
		product = field * 32'd255;
		quotient = product / full;
		return quotient[7:0];
	endfunction

	function automatic logic [23:0] decode_pixel(input logic [31:0] word);
		if (fmt_now == FMT_BITFIELDS) begin
			return {scale_channel(word, red_mask_now), scale_channel(word, green_mask_now),
				scale_channel(word, blue_mask_now)};
		end
		return word[23:0];
	endfunction

	function automatic logic [31:0] random_mask();
		int w;
		logic [31:0] run;
		w = $urandom_range(1, 32);
		run = (w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
		case ($urandom_range(0, 7))
			0: begin
				return 32'd0;
			end
			1: begin
				return 32'hFFFF_FFFF;
			end
			2: begin
				return 32'd1 << $urandom_range(0, 31);
			end
			6: begin
				return $urandom;
			end
			7: begin
				return run << (32 - w);
			end
			default: begin
				return run << $urandom_range(0, 32 - w);
			end
		endcase
	endfunction

	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_pixels.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= 10) begin
					$display("Unexpected result %h at %0t", xrgb_pixel, $realtime);
				end
			end else begin
				logic [23:0] want;
				want = expected_pixels.pop_front();
				pixels_checked++;
				if (xrgb_pixel !== want) begin
					mismatches++;
					if (mismatches + unexpected <= 10) begin
						$display("Mismatch on pixel %0d: expected %h, got %h", pixels_checked,
							want, xrgb_pixel);
					end
				end
			end
		end
	end

	task automatic send_pixel(input logic [31:0] word);
		int gap;
		start <= 1'b1;
		pixel_word <= word;
		do @(posedge clk); while (busy);
		expected_pixels.push_back(decode_pixel(word));
		pixels_sent++;
		formats_seen[fmt_now] = 1'b1;
		gap = random_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// The pipeline must be empty before the registers change under it.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (expected_pixels.size() != 0);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	task automatic configure(input logic [1:0] fmt, input logic [31:0] red,
		input logic [31:0] green, input logic [31:0] blue);
		logic [31:0] values[4];
		cfg_idx_t idx;
		values = '{{30'd0, fmt}, red, green, blue};
		for (int i = 0; i < 4; i++) begin
			idx = cfg_idx_t'(i);
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= (idx == CFG_FORMAT) ? ($urandom & 32'hFFFF_FFFC) | values[i] : values[i];
			do @(posedge clk); while (!cfg_ready);
			case (idx)
				CFG_FORMAT: fmt_now = cfg_data[1:0];
				CFG_RED_MASK: red_mask_now = cfg_data;
				CFG_GREEN_MASK: green_mask_now = cfg_data;
				CFG_BLUE_MASK: blue_mask_now = cfg_data;
			endcase
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic test_byte_formats();
		logic [31:0] words[3];
		words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA512_3456};
		// The first pass runs on the reset setting with no register write.
		foreach (words[i]) send_pixel(words[i]);
		drain();
		configure(FMT_BGRX32, 32'd0, 32'd0, 32'd0);
		foreach (words[i]) send_pixel(words[i]);
		drain();
		configure(FMT_SPARE, 32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF);
		foreach (words[i]) send_pixel(words[i]);
		drain();
	endtask

	task automatic test_bitfield_masks();
		configure(FMT_BITFIELDS, 32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF);
		send_pixel(32'h00FF_8001);
		send_pixel(32'hFFFF_FFFF);
		drain();
		configure(FMT_BITFIELDS, 32'h0000_F800, 32'h0000_07E0, 32'h0000_001F);
		send_pixel(32'h0000_FFFF);
		send_pixel(32'h0000_A5A5);
		drain();
		// Full-span, zero and top-bit-only masks; the full span also wraps the product.
		configure(FMT_BITFIELDS, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h8000_0000);
		send_pixel(32'h0123_4567);
		drain();
		configure(FMT_BITFIELDS, 32'h0F0F_0000, 32'h01FF_FFFF, 32'h0000_0001);
		send_pixel(32'h0F0F_0000);
		send_pixel(32'h01FF_FFFF);
		send_pixel(32'h00F0_0001);
		drain();
	endtask

	task automatic test_random_pixels();
		int pick;
		logic [1:0] fmt;
		logic [31:0] word;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			pick = $urandom_range(0, 9);
			fmt = (pick < 6) ? FMT_BITFIELDS : 2'(pick - 6);
			if (fmt == FMT_BITFIELDS && pick == 5) begin
				fmt = FMT_SPARE;
			end
			configure(fmt, random_mask(), random_mask(), random_mask());
			for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
				case ($urandom_range(0, 19))
					0: word = 32'd0;
					1: word = 32'hFFFF_FFFF;
					default: word = $urandom;
				endcase
				send_pixel(word);
			end
			drain();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_byte_formats();
		test_bitfield_masks();
		test_random_pixels();
		drain();
		$display("Sent %0d pixels under %0d register settings, format codes seen: %b.",
			pixels_sent, settings_used + 1, formats_seen);
		$display("Compared %0d results: %0d mismatches, %0d unexpected, %0d missing.",
			pixels_checked, mismatches, unexpected, expected_pixels.size());
		if (mismatches == 0 && unexpected == 0 && expected_pixels.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### sim.f
rtl/bmpx_pkg.sv
rtl/bmp_pixel_to_xrgb_converter.sv
verif/tb_top.sv
